// ===== hw/rtl/ket_pkg.sv =====
// Shared constants and types for the keyed entry table.
package ket_pkg;

	// Widths of the channel fields and of the config register
	localparam int FIELD_BITS = 64;
	localparam int USE_BITS   = 7;

	// Parameter defaults
	localparam int TABLE_SLOTS_DEF  = 64;
	localparam int ID_BITS_DEF      = 64;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Reset value of the slot-count register
	localparam logic [USE_BITS-1:0] USE_RESET = 7'd64;

	// Request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_KEY,
		ST_SCAN_FREE,
		ST_FINISH
	} state_t;

	// Memory write request from the sequencer
	typedef struct packed {
		logic en;
		logic clear;
	} wr_ctl_t;

endpackage

// ===== hw/rtl/ket_if.sv =====
// Request and response channel interfaces of the keyed entry table.
interface ket_req_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [ket_pkg::FIELD_BITS-1:0]  client_id;
	logic [ket_pkg::FIELD_BITS-1:0]  server_id;
	logic [ket_pkg::FIELD_BITS-1:0]  entry_payload;

	modport source (output valid, kind, client_id, server_id, entry_payload, input ready);
	modport sink   (input valid, kind, client_id, server_id, entry_payload, output ready);
endinterface

interface ket_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic                            matched_existing;
	logic [ket_pkg::FIELD_BITS-1:0]  payload_out;

	modport source (output valid, status, matched_existing, payload_out, input ready);
	modport sink   (input valid, status, matched_existing, payload_out, output ready);
endinterface

// ===== hw/rtl/ket_mem.sv =====
// Slot store: one write port, one read port, registered read data.
module ket_mem #(
	parameter int DEPTH = ket_pkg::TABLE_SLOTS_DEF,
	parameter int WIDTH = 2 * ket_pkg::ID_BITS_DEF + ket_pkg::PAYLOAD_BITS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== hw/rtl/keyed_entry_table_top.sv =====
// Top level of the keyed entry table: sequencer, config register and output register.
//
// Fully associative table of TABLE_SLOTS entries, each a (client, server) key
// pair of ID_BITS bits each plus a PAYLOAD_BITS payload, held in one
// single-port-read memory. Only the low ID_BITS / PAYLOAD_BITS of the request
// fields are used. A request is scanned against the first entries_in_use slots
// (saturated to TABLE_SLOTS) at one slot per cycle through the memory's
// registered read port, so the scan loop sets the rate. A read ends its scan at
// the first slot whose key matches, or after the last slot in use on a miss. A
// write ends at a matching slot; a new key scans all slots in use for a match
// and then again from slot zero up to its first free slot. With entries_in_use
// zero a request goes straight to the finish state without a scan. One
// request is in work at a time; the next beat is taken in the cycle after the
// result moves into the output register, even if that register is still waiting
// on its sink. After reset a clearing pass writes zero to every slot, during
// which no request is accepted; config writes are taken at any time but must
// only be issued while the block is idle.
module keyed_entry_table_top #(
	parameter int TABLE_SLOTS  = ket_pkg::TABLE_SLOTS_DEF,
	parameter int ID_BITS      = ket_pkg::ID_BITS_DEF,
	parameter int PAYLOAD_BITS = ket_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ket_pkg::USE_BITS-1:0]  cfg_wdata,
	ket_req_if.sink                       req,
	ket_rsp_if.source                     rsp
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int LW = AW + 1;                        // holds the slot count itself
	localparam int CW = (LW > ket_pkg::USE_BITS) ? LW : ket_pkg::USE_BITS;
	localparam int WW = 2 * ID_BITS + PAYLOAD_BITS;    // memory word: {client, server, payload}

	// Config register
	logic [ket_pkg::USE_BITS-1:0] use_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q <= ket_pkg::USE_RESET;
		end else if (cfg_we) begin
			use_q <= cfg_wdata;
		end
	end

	// Slots in use, saturated to the table depth
	logic [LW-1:0] lim;
	assign lim = (CW'(use_q) > CW'(TABLE_SLOTS)) ? LW'(TABLE_SLOTS) : LW'(use_q);

	// Sequencer state
	ket_pkg::state_t state_q, state_d;

	logic [LW-1:0]           iss_q;     // next slot to read, also clear counter
	logic                    v_s1;      // read data valid for addr_s1
	logic [AW-1:0]           addr_s1;
	logic                    kind_q;
	logic [ID_BITS-1:0]      cid_q;
	logic [ID_BITS-1:0]      sid_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    status_q;
	logic                    match_q;
	logic [PAYLOAD_BITS-1:0] pout_q;
	logic                    wr_pend_q;
	logic [AW-1:0]           dst_q;

	// Output register
	logic                            out_v_q;
	logic                            out_status_q;
	logic                            out_match_q;
	logic [ket_pkg::FIELD_BITS-1:0]  out_pout_q;
	logic                            out_free;

	assign out_free = !out_v_q || rsp.ready;

	// Memory port
	logic [WW-1:0]   rd_word;
	logic [AW-1:0]   wr_addr;
	logic [WW-1:0]   wr_data;
	logic [AW-1:0]   rd_addr;
	ket_pkg::wr_ctl_t wr_ctl;

	ket_mem #(
		.DEPTH (TABLE_SLOTS),
		.WIDTH (WW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_ctl.en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	// Compare of the slot just read
	logic [ID_BITS-1:0]      rd_cid;
	logic [ID_BITS-1:0]      rd_sid;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic                    key_hit;
	logic                    free_hit;
	logic                    last_s1;

	assign rd_cid   = rd_word[WW-1 -: ID_BITS];
	assign rd_sid   = rd_word[PAYLOAD_BITS +: ID_BITS];
	assign rd_pay   = rd_word[PAYLOAD_BITS-1:0];
	assign key_hit  = (rd_cid == cid_q) && (rd_sid == sid_q);
	assign free_hit = (rd_word == '0);
	assign last_s1  = ({1'b0, addr_s1} == (lim - LW'(1)));

	logic accept;
	logic issue;
	logic load_out;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ket_pkg::ST_CLEAR: begin
				if (iss_q == LW'(TABLE_SLOTS - 1)) state_d = ket_pkg::ST_IDLE;
			end
			ket_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = (lim == '0) ? ket_pkg::ST_FINISH : ket_pkg::ST_SCAN_KEY;
				end
			end
			ket_pkg::ST_SCAN_KEY: begin
				if (v_s1) begin
					priority if (key_hit) begin
						state_d = ket_pkg::ST_FINISH;
					end else if (last_s1) begin
						state_d = (kind_q == ket_pkg::KIND_READ) ? ket_pkg::ST_FINISH
							: ket_pkg::ST_SCAN_FREE;
					end else begin
						state_d = state_q;
					end
				end
			end
			ket_pkg::ST_SCAN_FREE: begin
				if (v_s1 && (free_hit || last_s1)) state_d = ket_pkg::ST_FINISH;
			end
			ket_pkg::ST_FINISH: begin
				if (out_free) state_d = ket_pkg::ST_IDLE;
			end
			default: state_d = ket_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready  = (state_q == ket_pkg::ST_IDLE);
		accept     = req.valid && (state_q == ket_pkg::ST_IDLE);
		issue      = ((state_q == ket_pkg::ST_SCAN_KEY) || (state_q == ket_pkg::ST_SCAN_FREE))
			&& (iss_q < lim);
		load_out   = (state_q == ket_pkg::ST_FINISH) && out_free;
		rd_addr    = iss_q[AW-1:0];
		wr_ctl.clear = (state_q == ket_pkg::ST_CLEAR);
		wr_ctl.en    = wr_ctl.clear || ((state_q == ket_pkg::ST_FINISH) && wr_pend_q);
		wr_addr    = wr_ctl.clear ? iss_q[AW-1:0] : dst_q;
		wr_data    = wr_ctl.clear ? '0 : {cid_q, sid_q, pay_q};
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ket_pkg::ST_CLEAR;
			iss_q     <= '0;
			v_s1      <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ket_pkg::ST_CLEAR: begin
					iss_q <= (iss_q == LW'(TABLE_SLOTS - 1)) ? '0 : iss_q + LW'(1);
				end
				ket_pkg::ST_IDLE: begin
					if (accept) begin
						iss_q     <= '0;
						v_s1      <= 1'b0;
						wr_pend_q <= 1'b0;
					end
				end
				ket_pkg::ST_SCAN_KEY, ket_pkg::ST_SCAN_FREE: begin
					// a hit or the last slot ends this pass; the in-flight read is dropped
					if (state_d != state_q) begin
						iss_q <= '0;
						v_s1  <= 1'b0;
					end else begin
						v_s1 <= issue;
						if (issue) iss_q <= iss_q + LW'(1);
					end
					if (v_s1 && (kind_q == ket_pkg::KIND_WRITE)) begin
						if ((state_q == ket_pkg::ST_SCAN_KEY && key_hit)
							|| (state_q == ket_pkg::ST_SCAN_FREE && free_hit)) begin
							wr_pend_q <= 1'b1;
						end
					end
				end
				ket_pkg::ST_FINISH: begin
					if (out_free) wr_pend_q <= 1'b0;
				end
				default: begin
					iss_q <= '0;
				end
			endcase
		end
	end

	// Request and result working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= req.kind;
			cid_q    <= req.client_id[ID_BITS-1:0];
			sid_q    <= req.server_id[ID_BITS-1:0];
			pay_q    <= req.entry_payload[PAYLOAD_BITS-1:0];
			status_q <= ket_pkg::STATUS_FAIL;
			match_q  <= 1'b0;
			pout_q   <= '0;
		end
		if (issue) addr_s1 <= iss_q[AW-1:0];
		if (v_s1 && (state_q == ket_pkg::ST_SCAN_KEY) && key_hit) begin
			status_q <= ket_pkg::STATUS_OK;
			match_q  <= 1'b1;
			dst_q    <= addr_s1;
			if (kind_q == ket_pkg::KIND_READ) pout_q <= rd_pay;
		end
		if (v_s1 && (state_q == ket_pkg::ST_SCAN_FREE) && free_hit) begin
			status_q <= ket_pkg::STATUS_OK;
			dst_q    <= addr_s1;
		end
	end

	// Output register: lets the next request start while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_match_q  <= match_q;
			out_pout_q   <= ket_pkg::FIELD_BITS'(pout_q);
		end
	end

	assign rsp.valid            = out_v_q;
	assign rsp.status           = out_status_q;
	assign rsp.matched_existing = out_match_q;
	assign rsp.payload_out      = out_pout_q;

endmodule
